>>> rtl/core/ddft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddft_pkg
// Shared types, widths, codes and the quarter-wave cosine ROM for the
// direct DFT engine.
// ----------------------------------------------------------------------------
package ddft_pkg;

  // Sizes
  localparam int MAX_POINTS  = 1024;
  localparam int LOG2_MAX    = $clog2(MAX_POINTS);
  localparam int MIN_LOG2    = 2;
  localparam int SAMPLE_BITS = 16;
  localparam int TW_W        = 16;
  localparam int PH_W        = LOG2_MAX;
  localparam int IDX_W       = 10;
  localparam int L2_W        = 4;
  localparam int OUT_W       = 27;
  localparam int PROD_W      = SAMPLE_BITS + TW_W;
  localparam int ACC_W       = PROD_W + LOG2_MAX + 2;
  localparam int RND_SHIFT   = 15;

  // Quarter wave geometry
  localparam int QTR  = MAX_POINTS / 4;
  localparam int HALF = MAX_POINTS / 2;
  localparam int TQTR = 3 * MAX_POINTS / 4;
  localparam int QI_W = $clog2(QTR + 1);

  // Register file
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_INVERSE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_POINTS  = 1'b1;
  localparam logic [L2_W-1:0]      POINTS_RESET = L2_W'(LOG2_MAX);

  // Output saturation limits, in accumulator width
  localparam logic signed [ACC_W-1:0] OUT_HI = ACC_W'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] OUT_LO = ACC_W'(-(2 ** (OUT_W - 1)));
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (RND_SHIFT - 1));

  // Request codes
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Control handed from the sequencer to the datapath
  typedef struct packed {
    logic issue;
    logic last;
    logic clear;
    logic inverse;
  } ddft_ctl_t;

  // Quarter-wave cosine table, Q1.15
  typedef logic signed [TW_W-1:0] qcos_t [QTR+1];

  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam int TAYLOR_TERMS = 11;
  localparam longint TAYLOR_DIV [1:11] = '{2, 12, 30, 56, 90, 132, 182, 240, 306,
                                           380, 462};

  // Build the table with a fixed-point Taylor series on the first quadrant
  function automatic qcos_t build_qcos();
    qcos_t  tbl;
    longint ang;
    longint x2;
    longint term;
    longint sum;
    longint q;
    for (int k = 0; k <= QTR; k++) begin
      ang  = (64'sd2 * PI_Q30 * longint'(k)) / MAX_POINTS;
      x2   = (ang * ang) >>> 30;
      term = ONE_Q30;
      sum  = ONE_Q30;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        term = (term * x2) >>> 30;
        term = term / TAYLOR_DIV[n];
        if ((n & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      q = (sum + 64'sd16384) >>> 15;
      if (q > 32767) begin
        q = 32767;
      end
      tbl[k] = TW_W'(q);
    end
    return tbl;
  endfunction

  localparam qcos_t QCOS = build_qcos();

  // Full-circle cosine from the quarter table by symmetry
  function automatic logic signed [TW_W-1:0] twiddle_cos(input logic [PH_W-1:0] k);
    logic [QI_W-1:0] qi;
    logic            neg;
    if (int'(k) <= QTR) begin
      qi  = QI_W'(k);
      neg = 1'b0;
    end else if (int'(k) <= HALF) begin
      qi  = QI_W'(HALF - int'(k));
      neg = 1'b1;
    end else if (int'(k) <= TQTR) begin
      qi  = QI_W'(int'(k) - HALF);
      neg = 1'b1;
    end else begin
      qi  = QI_W'(MAX_POINTS - int'(k));
      neg = 1'b0;
    end
    return neg ? -QCOS[qi] : QCOS[qi];
  endfunction

endpackage

>>> rtl/core/direct_dft_engine.sv
`timescale 1ns / 1ps
// Load transaction: accepted while idle, one load per cycle.
// Read transaction: the sequencer walks all N samples, N = 2^points_log2 clamped
//   to 4..1024, one sample memory read per cycle, then registers the result.
// Next transaction is accepted from the cycle after the result is registered;
//   a stalled result channel holds the result back and the engine with it.
// Reset clears the sequencer, valid flags and configuration registers (forward, length 1024); sample memory
//   is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
// direct_dft_engine
// Direct DFT: loads complex samples into a memory and computes single bins
// by walking the samples through a multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module direct_dft_engine (
  input  logic                                    clk,
  input  logic                                    rst,
  // Request channel
  input  logic                                    req_valid,
  output logic                                    req_stall,
  input  logic                                    action,
  input  logic [ddft_pkg::IDX_W-1:0]              index,
  input  logic signed [ddft_pkg::SAMPLE_BITS-1:0] sample_re,
  input  logic signed [ddft_pkg::SAMPLE_BITS-1:0] sample_im,
  // Result channel
  output logic                                    bin_valid,
  input  logic                                    bin_stall,
  output logic signed [ddft_pkg::OUT_W-1:0]       bin_re,
  output logic signed [ddft_pkg::OUT_W-1:0]       bin_im,
  output logic [ddft_pkg::IDX_W-1:0]              bin_number,
  // Configuration port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [ddft_pkg::ADDR_W-1:0]             paddr,
  input  logic [ddft_pkg::DATA_W-1:0]             pwdata,
  output logic [ddft_pkg::DATA_W-1:0]             prdata,
  output logic                                    pready
);
  import ddft_pkg::*;

  state_t                    state;
  state_t                    state_next;
  logic                      inverse_mode;
  logic [L2_W-1:0]           points_log2;
  logic [L2_W-1:0]           l_eff;
  logic [REG_IDX_W-1:0]      reg_idx;
  logic                      cfg_write;
  logic                      req_take;
  logic                      start;
  logic                      load;
  logic [PH_W-1:0]           t;
  logic [PH_W-1:0]           last_t;
  logic [PH_W-1:0]           phase;
  logic [PH_W-1:0]           step;
  logic [IDX_W-1:0]          req_bin;
  logic                      issue;
  logic                      out_load;
  logic                      acc_done;
  logic signed [OUT_W-1:0]   sum_re;
  logic signed [OUT_W-1:0]   sum_im;
  logic [2*SAMPLE_BITS-1:0]  mem [MAX_POINTS];
  logic [2*SAMPLE_BITS-1:0]  rd_data;
  ddft_ctl_t                 ctl;

  // Configuration registers
  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
      points_log2  <= POINTS_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_INVERSE: inverse_mode <= pwdata[0];
        REG_POINTS:  points_log2  <= pwdata[L2_W-1:0];
        default:     inverse_mode <= inverse_mode;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INVERSE: prdata = DATA_W'(inverse_mode);
      REG_POINTS:  prdata = DATA_W'(points_log2);
      default:     prdata = '0;
    endcase
  end

  // Clamp the length to the supported range
  always_comb begin
    if (points_log2 < L2_W'(MIN_LOG2)) begin
      l_eff = L2_W'(MIN_LOG2);
    end else if (points_log2 > L2_W'(LOG2_MAX)) begin
      l_eff = L2_W'(LOG2_MAX);
    end else begin
      l_eff = points_log2;
    end
  end

  // Request decode
  assign req_take = req_valid & ~req_stall;
  assign start    = req_take & (action == ACT_READ);
  assign load     = req_take & (action == ACT_LOAD);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_RUN;
      ST_RUN:   if (t == last_t) state_next = ST_DRAIN;
      ST_DRAIN: if (acc_done) state_next = ST_DONE;
      ST_DONE:  if (!bin_valid || !bin_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer outputs
  always_comb begin
    req_stall = 1'b1;
    issue     = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:  req_stall = 1'b0;
      ST_RUN:   issue = 1'b1;
      ST_DRAIN: issue = 1'b0;
      ST_DONE:  out_load = ~bin_valid | ~bin_stall;
      default:  req_stall = 1'b1;
    endcase
  end

  // Sample counter and twiddle phase; latch the bin on start
  always_ff @(posedge clk) begin
    if (start) begin
      t       <= '0;
      phase   <= '0;
      step    <= PH_W'(index << (LOG2_MAX - int'(l_eff)));
      last_t  <= PH_W'((1 << l_eff) - 1);
      req_bin <= index;
    end else if (issue) begin
      t     <= t + PH_W'(1);
      phase <= phase + step;
    end
  end

  // Sample memory: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (load) begin
      mem[index[PH_W-1:0]] <= {sample_re, sample_im};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[t];
  end

  // Datapath control
  always_comb begin
    ctl.issue   = issue;
    ctl.last    = (t == last_t);
    ctl.clear   = start;
    ctl.inverse = inverse_mode;
  end

  ddft_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .phase    (phase),
    .x_re     (rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .x_im     (rd_data[SAMPLE_BITS-1:0]),
    .acc_done (acc_done),
    .sum_re   (sum_re),
    .sum_im   (sum_im)
  );

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= 1'b0;
    end else if (out_load) begin
      bin_valid <= 1'b1;
    end else if (!bin_stall) begin
      bin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bin_re     <= sum_re;
      bin_im     <= sum_im;
      bin_number <= req_bin;
    end
  end

endmodule

>>> rtl/core/ddft_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddft_datapath
// Twiddle lookup, complex multiply and exact accumulation for one bin,
// followed by rounding and saturation of the finished sums.
// ----------------------------------------------------------------------------
module ddft_datapath (
  input  logic                                      clk,
  input  logic                                      rst,
  input  ddft_pkg::ddft_ctl_t                       ctl,
  input  logic [ddft_pkg::PH_W-1:0]                 phase,
  input  logic signed [ddft_pkg::SAMPLE_BITS-1:0]   x_re,
  input  logic signed [ddft_pkg::SAMPLE_BITS-1:0]   x_im,
  output logic                                      acc_done,
  output logic signed [ddft_pkg::OUT_W-1:0]         sum_re,
  output logic signed [ddft_pkg::OUT_W-1:0]         sum_im
);
  import ddft_pkg::*;

  logic signed [TW_W-1:0]   cos_q;
  logic signed [TW_W-1:0]   sin_q;
  logic                     v1;
  logic                     last1;
  logic signed [PROD_W-1:0] p_rc;
  logic signed [PROD_W-1:0] p_is;
  logic signed [PROD_W-1:0] p_ic;
  logic signed [PROD_W-1:0] p_rs;
  logic                     v2;
  logic                     last2;
  logic signed [ACC_W-1:0]  acc_re;
  logic signed [ACC_W-1:0]  acc_im;
  logic signed [ACC_W-1:0]  term_re;
  logic signed [ACC_W-1:0]  term_im;
  logic signed [ACC_W-1:0]  rnd_re;
  logic signed [ACC_W-1:0]  rnd_im;
  logic [PH_W-1:0]          sin_phase;

  // Sine is the cosine three quarters of a turn on
  assign sin_phase = phase + PH_W'(TQTR);

  // Stage 1: twiddle ROM, aligned with the sample memory read
  always_ff @(posedge clk) begin
    cos_q <= twiddle_cos(phase);
    sin_q <= twiddle_cos(sin_phase);
    last1 <= ctl.last;
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
    end
  end

  // Stage 2: four real products
  always_ff @(posedge clk) begin
    p_rc  <= x_re * cos_q;
    p_is  <= x_im * sin_q;
    p_ic  <= x_im * cos_q;
    p_rs  <= x_re * sin_q;
    last2 <= last1;
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  // Combine products by direction
  always_comb begin
    if (ctl.inverse) begin
      term_re = ACC_W'(p_rc) - ACC_W'(p_is);
      term_im = ACC_W'(p_ic) + ACC_W'(p_rs);
    end else begin
      term_re = ACC_W'(p_rc) + ACC_W'(p_is);
      term_im = ACC_W'(p_ic) - ACC_W'(p_rs);
    end
  end

  // Stage 3: exact accumulation
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v2) begin
      acc_re <= acc_re + term_re;
      acc_im <= acc_im + term_im;
    end
  end

  assign acc_done = v2 & last2;

  // Round half up by 15 bits, then saturate
  always_comb begin
    rnd_re = (acc_re + RND_HALF) >>> RND_SHIFT;
    rnd_im = (acc_im + RND_HALF) >>> RND_SHIFT;
    if (rnd_re > OUT_HI) begin
      sum_re = OUT_HI[OUT_W-1:0];
    end else if (rnd_re < OUT_LO) begin
      sum_re = OUT_LO[OUT_W-1:0];
    end else begin
      sum_re = rnd_re[OUT_W-1:0];
    end
    if (rnd_im > OUT_HI) begin
      sum_im = OUT_HI[OUT_W-1:0];
    end else if (rnd_im < OUT_LO) begin
      sum_im = OUT_LO[OUT_W-1:0];
    end else begin
      sum_im = rnd_im[OUT_W-1:0];
    end
  end

endmodule
